/* hdl/rwlt_pkg.sv */
// ----------------------------------------------------------------------------
// Reader/writer lock table package
// Opcodes, status codes, field widths and sequencer states shared by the
// lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package rwlt_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 16;

  localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WCONF   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RCONF   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHELD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVF     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

endpackage

`default_nettype wire

/* hdl/reader_writer_lock_table.sv */
// ----------------------------------------------------------------------------
// Reader/writer lock table
// Keeps a table of keys with reader and writer counts and answers lock,
// unlock and query requests, one result word per request word.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy then
// stays high until the result word is shown. The table sits in a memory
// with one read and one write port, and one key comparator walks it one
// entry per cycle. A request ends its walk at the entry that holds its
// key, or walks the whole table when the key is absent. Busy is low during
// the result cycle, so the next request word can be taken at the edge that
// ends it. The result word is on the outputs for exactly one cycle, marked
// by done_o, and must be taken then: the block does not wait for the
// receiver. No clearing pass is needed after reset.
`default_nettype none

module reader_writer_lock_table #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [rwlt_pkg::OP_W-1:0]         opcode_i,
  input  wire  [rwlt_pkg::KEY_W-1:0]        key_i,
  input  wire                               mode_i,
  input  wire                               force_req_i,
  output logic                              done_o,
  output logic [rwlt_pkg::STATUS_W-1:0]     status_o,
  output logic [rwlt_pkg::CNT_W-1:0]        conflict_count_o,
  output logic [rwlt_pkg::CNT_W-1:0]        read_count_o,
  output logic [rwlt_pkg::CNT_W-1:0]        write_count_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned SKEY_W = (KEY_BITS < rwlt_pkg::KEY_W) ? KEY_BITS : rwlt_pkg::KEY_W;
  localparam int unsigned WORD_W = SKEY_W + 2 * COUNT_BITS;
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  function automatic logic [rwlt_pkg::CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[rwlt_pkg::CNT_W-1:0];
  endfunction

  rwlt_pkg::state_e state_q, state_d;

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [ENTRIES-1:0] valid_q, valid_d;

  logic [rwlt_pkg::OP_W-1:0] op_q, op_d;
  logic [SKEY_W-1:0]         key_q, key_d;
  logic                      mode_q, mode_d;
  logic                      force_q, force_d;

  logic [IDX_W-1:0]      addr_q, addr_d;
  logic                  issue_q, issue_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  cmp_valid_q, cmp_valid_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [COUNT_BITS-1:0] hit_rc_q, hit_rc_d;
  logic [COUNT_BITS-1:0] hit_wc_q, hit_wc_d;
  logic                  free_found_q, free_found_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;

  logic                           done_q, done_d;
  logic [rwlt_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [COUNT_BITS-1:0]          conflict_q, conflict_d;
  logic [COUNT_BITS-1:0]          rc_out_q, rc_out_d;
  logic [COUNT_BITS-1:0]          wc_out_q, wc_out_d;

  logic [SKEY_W-1:0]     rd_key;
  logic [COUNT_BITS-1:0] rd_rc;
  logic [COUNT_BITS-1:0] rd_wc;
  logic                  key_match;

  logic [COUNT_BITS-1:0] new_rc;
  logic [COUNT_BITS-1:0] new_wc;
  logic [COUNT_BITS-1:0] sel_cnt;

  assign rd_key    = rdata_q[WORD_W-1 -: SKEY_W];
  assign rd_rc     = rdata_q[2*COUNT_BITS-1 -: COUNT_BITS];
  assign rd_wc     = rdata_q[COUNT_BITS-1:0];
  assign key_match = cmp_vld_q && cmp_valid_q && (rd_key == key_q);
  assign sel_cnt   = mode_q ? hit_wc_q : hit_rc_q;

  assign busy             = (state_q != rwlt_pkg::S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign conflict_count_o = to_out(conflict_q);
  assign read_count_o     = to_out(rc_out_q);
  assign write_count_o    = to_out(wc_out_q);

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    op_d         = op_q;
    key_d        = key_q;
    mode_d       = mode_q;
    force_d      = force_q;
    addr_d       = addr_q;
    issue_d      = issue_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = addr_q;
    cmp_valid_d  = valid_q[addr_q];
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_rc_d     = hit_rc_q;
    hit_wc_d     = hit_wc_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    done_d       = 1'b0;
    status_d     = status_q;
    conflict_d   = conflict_q;
    rc_out_d     = rc_out_q;
    wc_out_d     = wc_out_q;
    mem_we       = 1'b0;
    mem_waddr    = hit_idx_q;
    new_rc       = hit_rc_q;
    new_wc       = hit_wc_q;

    case (state_q)
      rwlt_pkg::S_IDLE: begin
        if (start) begin
          op_d         = opcode_i;
          key_d        = key_i[SKEY_W-1:0];
          mode_d       = mode_i;
          force_d      = force_req_i;
          addr_d       = '0;
          issue_d      = 1'b1;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          state_d      = rwlt_pkg::S_SCAN;
        end
      end

      rwlt_pkg::S_SCAN: begin
        if (key_match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_rc_d  = rd_rc;
          hit_wc_d  = rd_wc;
          issue_d   = 1'b0;
          state_d   = rwlt_pkg::S_EXEC;
        end else begin
          if (cmp_vld_q && !cmp_valid_q && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          if (issue_q) begin
            cmp_vld_d = 1'b1;
            addr_d    = addr_q + IDX_W'(1);
            if (addr_q == LAST_IDX) begin
              issue_d = 1'b0;
            end
          end
          if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
            state_d = rwlt_pkg::S_EXEC;
          end
        end
      end

      rwlt_pkg::S_EXEC: begin
        done_d     = 1'b1;
        state_d    = rwlt_pkg::S_IDLE;
        status_d   = rwlt_pkg::ST_OK;
        conflict_d = CNT_ZERO;
        rc_out_d   = hit_q ? hit_rc_q : CNT_ZERO;
        wc_out_d   = hit_q ? hit_wc_q : CNT_ZERO;
        case (op_q)
          rwlt_pkg::OP_LOCK: begin
            if (!hit_q) begin
              if (!free_found_q) begin
                status_d = rwlt_pkg::ST_FULL;
              end else begin
                new_rc               = mode_q ? CNT_ZERO : CNT_ONE;
                new_wc               = mode_q ? CNT_ONE : CNT_ZERO;
                mem_we               = 1'b1;
                mem_waddr            = free_idx_q;
                valid_d[free_idx_q]  = 1'b1;
                rc_out_d             = new_rc;
                wc_out_d             = new_wc;
              end
            end else if (!mode_q) begin
              if ((hit_wc_q != CNT_ZERO) && !force_q) begin
                status_d   = rwlt_pkg::ST_WCONF;
                conflict_d = hit_wc_q;
              end else if (hit_rc_q == CNT_MAX) begin
                status_d = rwlt_pkg::ST_OVF;
              end else begin
                new_rc   = hit_rc_q + CNT_ONE;
                mem_we   = 1'b1;
                rc_out_d = new_rc;
              end
            end else begin
              if (((hit_rc_q != CNT_ZERO) || (hit_wc_q != CNT_ZERO)) && !force_q) begin
                if (hit_wc_q != CNT_ZERO) begin
                  status_d   = rwlt_pkg::ST_WCONF;
                  conflict_d = hit_wc_q;
                end else begin
                  status_d   = rwlt_pkg::ST_RCONF;
                  conflict_d = hit_rc_q;
                end
              end else if (hit_wc_q == CNT_MAX) begin
                status_d = rwlt_pkg::ST_OVF;
              end else begin
                new_wc   = hit_wc_q + CNT_ONE;
                mem_we   = 1'b1;
                wc_out_d = new_wc;
              end
            end
          end

          rwlt_pkg::OP_UNLOCK: begin
            if (!hit_q || (sel_cnt == CNT_ZERO)) begin
              status_d = rwlt_pkg::ST_NOTHELD;
            end else begin
              if (mode_q) begin
                new_wc = hit_wc_q - CNT_ONE;
              end else begin
                new_rc = hit_rc_q - CNT_ONE;
              end
              if ((new_rc == CNT_ZERO) && (new_wc == CNT_ZERO)) begin
                valid_d[hit_idx_q] = 1'b0;
              end else begin
                mem_we = 1'b1;
              end
              rc_out_d = new_rc;
              wc_out_d = new_wc;
            end
          end

          default: begin
          end
        endcase
      end

      default: begin
        state_d = rwlt_pkg::S_IDLE;
      end
    endcase
  end

  assign mem_wdata = {key_q, new_rc, new_wc};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rwlt_pkg::S_IDLE;
      valid_q      <= '0;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      issue_q      <= issue_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    mode_q      <= mode_d;
    force_q     <= force_d;
    addr_q      <= addr_d;
    cmp_idx_q   <= cmp_idx_d;
    cmp_valid_q <= cmp_valid_d;
    hit_idx_q   <= hit_idx_d;
    hit_rc_q    <= hit_rc_d;
    hit_wc_q    <= hit_wc_d;
    free_idx_q  <= free_idx_d;
    status_q    <= status_d;
    conflict_q  <= conflict_d;
    rc_out_q    <= rc_out_d;
    wc_out_q    <= wc_out_d;
  end

endmodule

`default_nettype wire
